// ===== hdl/urb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urb_pkg
// Types and codes shared by the UART ring buffer pair and its ring module.
// ----------------------------------------------------------------------------
package urb_pkg;

    // event codes carried in the mode field
    localparam logic [1:0] MODE_PUT      = 2'd0;
    localparam logic [1:0] MODE_TAKE     = 2'd1;
    localparam logic [1:0] MODE_RECV     = 2'd2;
    localparam logic [1:0] MODE_TX_READY = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic       accepted;
        logic [7:0] read_byte;
        logic       send_valid;
        logic [7:0] send_byte;
        logic       rx_overrun;
        logic       rx_available;
        logic       tx_full;
        logic       sending;
    } result_t;

    // request from the event logic to one ring
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } ring_ctl_t;

    // ring status now and after the requested push or pop
    typedef struct packed {
        logic empty;
        logic full;
        logic empty_next;
        logic full_next;
    } ring_sts_t;

endpackage

// ===== hdl/urb_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urb_ring
// Circular byte buffer: head/tail pointers, one-write one-read memory,
// registered read data. Holds DEPTH-1 bytes.
// ----------------------------------------------------------------------------
module urb_ring #(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  urb_pkg::ring_ctl_t ctl,
    output urb_pkg::ring_sts_t sts,
    output logic [7:0]        rdata
);
    import urb_pkg::*;

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] head_inc, tail_inc, head_next_inc;

    assign head_inc      = (head_reg == LAST) ? '0 : head_reg + AW'(1);
    assign tail_inc      = (tail_reg == LAST) ? '0 : tail_reg + AW'(1);
    assign head_next_inc = (head_next == LAST) ? '0 : head_next + AW'(1);

    assign head_next = ctl.push ? head_inc : head_reg;
    assign tail_next = ctl.pop  ? tail_inc : tail_reg;

    assign sts.empty      = (head_reg == tail_reg);
    assign sts.full       = (head_inc == tail_reg);
    assign sts.empty_next = (head_next == tail_next);
    assign sts.full_next  = (head_next_inc == tail_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem[head_reg] <= ctl.wdata;
        if (ctl.pop)
            rdata_reg <= mem[tail_reg];
    end

    assign rdata = rdata_reg;

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> !sts.full)
        else $error("push into full ring");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> !sts.empty)
        else $error("pop from empty ring");
    a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctl.push && !ctl.pop) |=> $stable(head_reg) && $stable(tail_reg))
        else $error("ring pointer moved without request");
`endif

endmodule

// ===== hdl/uart_ring_buffer_pair_top.sv =====
`timescale 1ns / 1ps
// A result strobes on done once its item has passed the input and result registers.
// Throughput: one item per cycle; busy is never raised.
// The path is input register, event logic with one ring access, result register.
// Reset clears pointers, sending flag and the valid and done strobes; buffer contents stay undefined.
// Results cannot be stalled: each is shown on result for the one cycle done is high.
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair_top
// Transmit and receive circular buffers between host and serial line,
// one event per item.
// ----------------------------------------------------------------------------
module uart_ring_buffer_pair_top #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  urb_pkg::cmd_t   cmd,
    output logic            done,
    output urb_pkg::result_t result
);
    import urb_pkg::*;

    logic      in_valid_reg;
    cmd_t      in_reg;
    ring_ctl_t tx_ctl, rx_ctl;
    ring_sts_t tx_sts, rx_sts;
    logic [7:0] tx_rdata, rx_rdata;

    logic running_reg, running_next;
    logic acc, ovr, sv, take_ok;

    logic done_reg;
    logic acc_reg, take_reg, sv_reg, ovr_reg;
    logic rx_avail_reg, tx_full_reg, sending_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            in_reg <= cmd;
    end

    always_comb
    begin
        tx_ctl       = '0;
        rx_ctl       = '0;
        tx_ctl.wdata = in_reg.data_byte;
        rx_ctl.wdata = in_reg.data_byte;
        acc          = 1'b0;
        ovr          = 1'b0;
        sv           = 1'b0;
        take_ok      = 1'b0;
        running_next = running_reg;
        if (in_valid_reg)
        begin
            case (in_reg.mode)
                MODE_PUT:
                begin
                    if (!tx_sts.full)
                    begin
                        tx_ctl.push  = 1'b1;
                        running_next = 1'b1;
                        acc          = 1'b1;
                    end
                end
                MODE_TAKE:
                begin
                    if (!rx_sts.empty)
                    begin
                        rx_ctl.pop = 1'b1;
                        take_ok    = 1'b1;
                        acc        = 1'b1;
                    end
                end
                MODE_RECV:
                begin
                    if (!rx_sts.full)
                    begin
                        rx_ctl.push = 1'b1;
                        acc         = 1'b1;
                    end
                    else
                        ovr = 1'b1;
                end
                MODE_TX_READY:
                begin
                    if (running_reg)
                    begin
                        if (!tx_sts.empty)
                        begin
                            tx_ctl.pop = 1'b1;
                            sv         = 1'b1;
                        end
                        // stop once the drain leaves the buffer empty
                        if (tx_sts.empty_next)
                            running_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    urb_ring #(.DEPTH(BUFFER_DEPTH)) u_tx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tx_ctl),
        .sts   (tx_sts),
        .rdata (tx_rdata)
    );

    urb_ring #(.DEPTH(BUFFER_DEPTH)) u_rx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rx_ctl),
        .sts   (rx_sts),
        .rdata (rx_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc;
        take_reg     <= take_ok;
        sv_reg       <= sv;
        ovr_reg      <= ovr;
        rx_avail_reg <= !rx_sts.empty_next;
        tx_full_reg  <= tx_sts.full_next;
        sending_reg  <= running_next;
    end

    // read data comes straight from the ring's registered read port
    assign done                = done_reg;
    assign result.accepted     = acc_reg;
    assign result.read_byte    = take_reg ? rx_rdata : 8'h00;
    assign result.send_valid   = sv_reg;
    assign result.send_byte    = sv_reg ? tx_rdata : 8'h00;
    assign result.rx_overrun   = ovr_reg;
    assign result.rx_available = rx_avail_reg;
    assign result.tx_full      = tx_full_reg;
    assign result.sending      = sending_reg;

`ifndef NO_ASSERTIONS
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("item produced no result");
    a_acc_ovr: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.accepted && result.rx_overrun))
        else $error("overrun on accepted item");
    a_full_sending: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.tx_full) |-> result.sending)
        else $error("transmit buffer full while sending stopped");
`endif

endmodule

// ===== bench/uart_ring_buffer_pair_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair_top_tb
// Self-checking bench for the UART ring buffer pair. Host puts, host takes,
// line receives and transmitter-ready events are issued in random bursts.
// An in-bench model of both rings predicts every result, and each strobed
// result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module uart_ring_buffer_pair_top_tb;
    import urb_pkg::*;

    localparam int DEPTH      = 64;
    localparam int AW         = $clog2(DEPTH);
    localparam int WDOG_LIMIT = 2000;
    localparam int DRAIN_WAIT = 8;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    uart_ring_buffer_pair_top #(
        .BUFFER_DEPTH(DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .result(result)
    );

    always #6 clk = ~clk;

    // ring model state
    logic [7:0]    tx_store [DEPTH];
    logic [7:0]    rx_store [DEPTH];
    logic [AW-1:0] tx_wr = '0, tx_rd = '0, rx_wr = '0, rx_rd = '0;
    logic          tx_running = 1'b0;

    result_t pending_results [$];
    int      errors = 0;
    int      burst_left = 0;
    int      idle_cycles = 0;

    // coverage tallies
    int mode_count [4] = '{0, 0, 0, 0};
    int n_sent = 0, n_taken = 0, n_overrun = 0, n_refused = 0, n_tx_full = 0;

    function automatic logic [AW-1:0] ring_next(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic result_t apply_uart_event(cmd_t c);
        result_t       r;
        logic [AW-1:0] nxt;
        r = '0;
        mode_count[c.mode]++;
        case (c.mode)
            MODE_PUT:
            begin
                nxt = ring_next(tx_wr);
                if (nxt != tx_rd)
                begin
                    tx_store[tx_wr] = c.data_byte;
                    tx_wr = nxt;
                    tx_running = 1'b1;
                    r.accepted = 1'b1;
                end
                else
                begin
                    n_refused++;
                end
            end
            MODE_TAKE:
            begin
                if (rx_wr != rx_rd)
                begin
                    r.read_byte = rx_store[rx_rd];
                    rx_rd = ring_next(rx_rd);
                    r.accepted = 1'b1;
                    n_taken++;
                end
                else
                begin
                    n_refused++;
                end
            end
            MODE_RECV:
            begin
                nxt = ring_next(rx_wr);
                if (nxt != rx_rd)
                begin
                    rx_store[rx_wr] = c.data_byte;
                    rx_wr = nxt;
                    r.accepted = 1'b1;
                end
                else
                begin
                    r.rx_overrun = 1'b1;
                    n_overrun++;
                end
            end
            MODE_TX_READY:
            begin
                if (tx_running)
                begin
                    if (tx_wr != tx_rd)
                    begin
                        r.send_byte = tx_store[tx_rd];
                        r.send_valid = 1'b1;
                        tx_rd = ring_next(tx_rd);
                        n_sent++;
                    end
                    // sending stops once the transmit ring drains
                    if (tx_rd == tx_wr)
                        tx_running = 1'b0;
                end
            end
            default: ;
        endcase
        r.rx_available = (rx_wr != rx_rd);
        r.tx_full      = (ring_next(tx_wr) == tx_rd);
        r.sending      = tx_running;
        if (r.tx_full)
            n_tx_full++;
        return r;
    endfunction

    // one item per call; start stays high across back-to-back items
    task automatic issue_event(input cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        pending_results.push_back(apply_uart_event(c));
    endtask

    task automatic issue(input logic [1:0] m, input logic [7:0] b);
        cmd_t c;
        c.mode      = m;
        c.data_byte = b;
        issue_event(c);
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // empty-ring refusals, idle transmitter, byte extremes, stop of sending
    task automatic test_basic_events();
        issue(MODE_TAKE, 8'hFF);
        issue(MODE_TX_READY, 8'h00);
        issue(MODE_RECV, 8'h00);
        issue(MODE_RECV, 8'hFF);
        issue(MODE_RECV, 8'h5A);
        issue(MODE_TAKE, 8'h00);
        issue(MODE_TAKE, 8'h00);
        issue(MODE_TAKE, 8'h00);
        issue(MODE_TAKE, 8'h00);
        issue(MODE_PUT, 8'hFF);
        issue(MODE_PUT, 8'h00);
        issue(MODE_TX_READY, 8'hFF);
        issue(MODE_TX_READY, 8'hFF);
        issue(MODE_TX_READY, 8'h00);
        issue(MODE_PUT, 8'hA5);
        issue(MODE_RECV, 8'h3C);
        issue(MODE_TX_READY, 8'h00);
        issue(MODE_TAKE, 8'h00);
        pause_until_drained();
    endtask

    // fill both rings to the brim, push past it, then drain them
    task automatic test_full_rings();
        int k;
        for (k = 0; k < DEPTH + 1; k++)
            issue(MODE_PUT, 8'($urandom_range(0, 255)));
        for (k = 0; k < DEPTH; k++)
            issue(MODE_TX_READY, 8'($urandom_range(0, 255)));
        for (k = 0; k < DEPTH + 1; k++)
            issue(MODE_RECV, 8'($urandom_range(0, 255)));
        for (k = 0; k < DEPTH; k++)
            issue(MODE_TAKE, 8'($urandom_range(0, 255)));
        pause_until_drained();
    endtask

    // fill levels wander: each epoch biases each ring toward filling or draining
    task automatic test_random_traffic(input int n_items);
        int   k, epoch_left, tx_fill_pct, rx_fill_pct;
        cmd_t c;
        epoch_left = 0;
        for (k = 0; k < n_items; k++)
        begin
            if (epoch_left == 0)
            begin
                epoch_left  = $urandom_range(30, 120);
                tx_fill_pct = $urandom_range(3, 97);
                rx_fill_pct = $urandom_range(3, 97);
            end
            epoch_left--;
            c.data_byte = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1))
                c.mode = ($urandom_range(1, 100) <= tx_fill_pct) ? MODE_PUT : MODE_TX_READY;
            else
                c.mode = ($urandom_range(1, 100) <= rx_fill_pct) ? MODE_RECV : MODE_TAKE;
            issue_event(c);
        end
        pause_until_drained();
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result strobed with no item outstanding");
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("accepted",     8'(exp_r.accepted),     8'(result.accepted));
                check_field("read_byte",    exp_r.read_byte,        result.read_byte);
                check_field("send_valid",   8'(exp_r.send_valid),   8'(result.send_valid));
                check_field("send_byte",    exp_r.send_byte,        result.send_byte);
                check_field("rx_overrun",   8'(exp_r.rx_overrun),   8'(result.rx_overrun));
                check_field("rx_available", 8'(exp_r.rx_available), 8'(result.rx_available));
                check_field("tx_full",      8'(exp_r.tx_full),      8'(result.tx_full));
                check_field("sending",      8'(exp_r.sending),      8'(result.sending));
            end
        end
    end

    // watchdog: cycles with neither an accepted item nor a result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("timeout: no activity for %0d cycles", WDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_events();
        test_full_rings();
        test_random_traffic(224);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Events: %0d puts, %0d takes, %0d line bytes, %0d tx-ready",
                 mode_count[MODE_PUT], mode_count[MODE_TAKE],
                 mode_count[MODE_RECV], mode_count[MODE_TX_READY]);
        $display("Sent %0d, taken %0d, overruns %0d, refusals %0d, tx-full results %0d",
                 n_sent, n_taken, n_overrun, n_refused, n_tx_full);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
